[rtl/pair_gravity_force_top_defines.svh]
// Assertion shorthands used by the checker file.
`ifndef PAIR_GRAVITY_FORCE_TOP_DEFINES_SVH
`define PAIR_GRAVITY_FORCE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PGF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PGF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pgf_pkg.sv]
package pgf_pkg;

	localparam int C_W   = 32;          // coordinate, mass and register width
	localparam int D_W   = C_W + 1;     // coordinate difference
	localparam int A_W   = C_W;         // magnitude of a difference
	localparam int GM_W  = 2 * C_W;     // G * m1
	localparam int K_W   = 3 * C_W;     // G * m1 * m2
	localparam int R2_W  = 2 * A_W + 1; // squared distance
	localparam int RT_W  = A_W + 1;     // distance
	localparam int SR_W  = RT_W + 3;    // square root remainder
	localparam int MAG_W = 60;          // force magnitude and component quotients
	localparam int HALF_W = MAG_W / 2;
	localparam int P_W   = HALF_W + A_W;
	localparam int N_W   = MAG_W + A_W; // magnitude times difference
	localparam int F_W   = 48;          // force component

	localparam int MAG_STEPS = MAG_W;
	localparam int RT_STEPS  = RT_W;

	localparam logic [R2_W-1:0] MIN_R2   = R2_W'(25) << C_W;
	localparam logic [C_W-1:0]  G_RESET  = C_W'(65536);
	localparam logic [F_W-1:0]  POS_LIM  = {1'b0, {(F_W-1){1'b1}}};
	localparam logic [F_W-1:0]  NEG_LIM  = {1'b1, {(F_W-1){1'b0}}};

	localparam int IDX_W = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_GRAVITY = 2'd0,
		REG_GATE    = 2'd1,
		REG_LEVEL   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [C_W-1:0] first_x;
		logic signed [C_W-1:0] first_y;
		logic        [C_W-1:0] first_mass;
		logic signed [C_W-1:0] second_x;
		logic signed [C_W-1:0] second_y;
		logic        [C_W-1:0] second_mass;
	} in_t;

	typedef struct packed {
		logic signed [F_W-1:0] force_x;
		logic signed [F_W-1:0] force_y;
		logic                  applied;
		logic                  saturated;
	} out_t;

	typedef struct packed {
		logic applied;
		logic zero;
		logic neg_x;
		logic neg_y;
	} flags_t;

	typedef struct packed {
		flags_t          flags;
		logic [A_W-1:0]  ax;
		logic [A_W-1:0]  ay;
	} side_t;

	typedef struct packed {
		side_t           side;
		logic [R2_W-1:0] r2;
		logic [K_W-1:0]  k;
	} prep_t;

	typedef struct packed {
		side_t            side;
		logic [RT_W-1:0]  span;
		logic [MAG_W-1:0] mag;
	} mag_t;

	typedef struct packed {
		flags_t          flags;
		logic [RT_W-1:0] span;
		logic [N_W-1:0]  nx;
		logic [N_W-1:0]  ny;
	} scale_t;

	typedef struct packed {
		flags_t           flags;
		logic [MAG_W-1:0] qx;
		logic [MAG_W-1:0] qy;
	} comp_t;

endpackage

[rtl/pgf_prep.sv]
module pgf_prep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  pgf_pkg::in_t                   in_data,
	input  logic [pgf_pkg::C_W-1:0]        gravity,
	input  logic                           gate_en,
	input  logic signed [pgf_pkg::C_W-1:0] level,
	output logic                           out_valid,
	output pgf_pkg::prep_t                 out_data
);
	import pgf_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;

	logic [D_W-1:0]  dx_s1, dy_s1;
	logic [GM_W-1:0] gm_s1;
	logic [C_W-1:0]  m2_s1;
	logic            app_s1;

	side_t           side_s2;
	logic [GM_W-1:0] pkl_s2, pkh_s2;

	side_t           side_s3;
	logic [GM_W-1:0] sqx_s3, sqy_s3;
	logic [K_W-1:0]  k_s3;

	prep_t           p_s4;

	logic [D_W-1:0]  dx_in, dy_in;
	logic            app_in;
	logic [A_W-1:0]  ax, ay;
	logic [R2_W-1:0] r2;

	// Differences and the water gate
	always_comb begin
		dx_in  = {in_data.second_x[C_W-1], in_data.second_x}
			- {in_data.first_x[C_W-1], in_data.first_x};
		dy_in  = {in_data.second_y[C_W-1], in_data.second_y}
			- {in_data.first_y[C_W-1], in_data.first_y};
		app_in = !(gate_en && (in_data.first_y <= level));
	end

	// Absolute differences
	always_comb begin
		ax = dx_s1[D_W-1] ? A_W'(-dx_s1) : A_W'(dx_s1);
		ay = dy_s1[D_W-1] ? A_W'(-dy_s1) : A_W'(dy_s1);
	end

	// Squared distance, used by the short-range test
	always_comb begin
		r2 = R2_W'(sqx_s3) + R2_W'(sqy_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= dx_in;
			dy_s1  <= dy_in;
			gm_s1  <= GM_W'(gravity) * GM_W'(in_data.first_mass);
			m2_s1  <= in_data.second_mass;
			app_s1 <= app_in;

			side_s2.flags.applied <= app_s1;
			side_s2.flags.zero    <= 1'b0;
			side_s2.flags.neg_x   <= dx_s1[D_W-1];
			side_s2.flags.neg_y   <= dy_s1[D_W-1];
			side_s2.ax            <= ax;
			side_s2.ay            <= ay;
			pkl_s2 <= GM_W'(gm_s1[C_W-1:0]) * GM_W'(m2_s1);
			pkh_s2 <= GM_W'(gm_s1[GM_W-1:C_W]) * GM_W'(m2_s1);

			side_s3 <= side_s2;
			sqx_s3  <= GM_W'(side_s2.ax) * GM_W'(side_s2.ax);
			sqy_s3  <= GM_W'(side_s2.ay) * GM_W'(side_s2.ay);
			k_s3    <= K_W'(pkl_s2) + (K_W'(pkh_s2) << C_W);

			p_s4.side.flags.applied <= side_s3.flags.applied;
			p_s4.side.flags.zero    <= !side_s3.flags.applied || (r2 < MIN_R2);
			p_s4.side.flags.neg_x   <= side_s3.flags.neg_x;
			p_s4.side.flags.neg_y   <= side_s3.flags.neg_y;
			p_s4.side.ax            <= side_s3.ax;
			p_s4.side.ay            <= side_s3.ay;
			p_s4.r2                 <= r2;
			p_s4.k                  <= k_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = p_s4;

endmodule

[rtl/pgf_mag.sv]
module pgf_mag (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  pgf_pkg::prep_t  in_data,
	output logic            out_valid,
	output pgf_pkg::mag_t   out_data
);
	import pgf_pkg::*;

	// One step of G*m1*m2 / r2 and, in the first steps, of sqrt(r2)
	typedef struct packed {
		side_t            side;
		logic [R2_W-1:0]  d;
		logic [MAG_W-1:0] num;
		logic [R2_W-1:0]  rem;
		logic [MAG_W-1:0] q;
		logic [R2_W:0]    srad;
		logic [RT_W-1:0]  root;
		logic [SR_W-1:0]  srem;
	} mstage_t;

	mstage_t head;
	mstage_t pipe_s [MAG_STEPS];
	logic    v_s    [MAG_STEPS];

	// Load the dividend top bits and the radicand
	always_comb begin
		head.side = in_data.side;
		head.d    = in_data.r2;
		head.num  = in_data.k[MAG_W-1:0];
		head.rem  = R2_W'(in_data.k[K_W-1:MAG_W]);
		head.q    = '0;
		head.srad = {1'b0, in_data.r2};
		head.root = '0;
		head.srem = '0;
	end

	for (genvar i = 0; i < MAG_STEPS; i++) begin : g_step
		mstage_t         cur, nxt;
		logic            cur_v;
		logic [R2_W:0]   sh;
		logic            ge;
		logic [SR_W-1:0] srs, trial;
		logic            sge;

		if (i == 0) begin : g_first
			assign cur   = head;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = pipe_s[i-1];
			assign cur_v = v_s[i-1];
		end

		always_comb begin
			nxt = cur;
			// restoring division: one quotient bit
			sh      = {cur.rem, cur.num[MAG_W-1]};
			ge      = (sh >= {1'b0, cur.d});
			nxt.rem = ge ? R2_W'(sh - {1'b0, cur.d}) : R2_W'(sh);
			nxt.num = cur.num << 1;
			nxt.q   = {cur.q[MAG_W-2:0], ge};
			// digit-by-digit square root: one root bit
			srs   = {cur.srem[SR_W-3:0], cur.srad[R2_W:R2_W-1]};
			trial = SR_W'({cur.root, 2'b01});
			sge   = (srs >= trial);
			if (i < RT_STEPS) begin
				nxt.srem = sge ? (srs - trial) : srs;
				nxt.root = {cur.root[RT_W-2:0], sge};
				nxt.srad = cur.srad << 2;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[i] <= nxt;
			end
		end
	end

	assign out_valid     = v_s[MAG_STEPS-1];
	assign out_data.side = pipe_s[MAG_STEPS-1].side;
	assign out_data.span = pipe_s[MAG_STEPS-1].root;
	assign out_data.mag  = pipe_s[MAG_STEPS-1].q;

endmodule

[rtl/pgf_scale.sv]
module pgf_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  pgf_pkg::mag_t   in_data,
	output logic            out_valid,
	output pgf_pkg::scale_t out_data
);
	import pgf_pkg::*;

	logic            v_s1, v_s2;
	logic [P_W-1:0]  pxl_s1, pxh_s1, pyl_s1, pyh_s1;
	flags_t          flags_s1;
	logic [RT_W-1:0] dist_s1;
	scale_t          sc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Split the magnitude in halves, then recombine the partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			pxl_s1   <= P_W'(in_data.mag[HALF_W-1:0]) * P_W'(in_data.side.ax);
			pxh_s1   <= P_W'(in_data.mag[MAG_W-1:HALF_W]) * P_W'(in_data.side.ax);
			pyl_s1   <= P_W'(in_data.mag[HALF_W-1:0]) * P_W'(in_data.side.ay);
			pyh_s1   <= P_W'(in_data.mag[MAG_W-1:HALF_W]) * P_W'(in_data.side.ay);
			flags_s1 <= in_data.side.flags;
			dist_s1  <= in_data.span;

			sc_s2.flags <= flags_s1;
			sc_s2.span  <= dist_s1;
			sc_s2.nx    <= N_W'(pxl_s1) + (N_W'(pxh_s1) << HALF_W);
			sc_s2.ny    <= N_W'(pyl_s1) + (N_W'(pyh_s1) << HALF_W);
		end
	end

	assign out_valid = v_s2;
	assign out_data  = sc_s2;

endmodule

[rtl/pgf_comp.sv]
module pgf_comp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  pgf_pkg::scale_t in_data,
	output logic            out_valid,
	output pgf_pkg::comp_t  out_data
);
	import pgf_pkg::*;

	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [RT_W-1:0]  rem;
		logic [MAG_W-1:0] q;
	} lane_t;

	typedef struct packed {
		flags_t          flags;
		logic [RT_W-1:0] d;
		lane_t           lx;
		lane_t           ly;
	} cstage_t;

	// One restoring division step on a lane
	function automatic lane_t lane_step(input lane_t l, input logic [RT_W-1:0] d);
		logic [RT_W:0] sh;
		logic          ge;
		lane_t         r;
		sh    = {l.rem, l.num[MAG_W-1]};
		ge    = (sh >= {1'b0, d});
		r.rem = ge ? RT_W'(sh - {1'b0, d}) : RT_W'(sh);
		r.num = l.num << 1;
		r.q   = {l.q[MAG_W-2:0], ge};
		return r;
	endfunction

	cstage_t head;
	cstage_t pipe_s [MAG_STEPS];
	logic    v_s    [MAG_STEPS];

	// Load both dividends; the distance divides both lanes
	always_comb begin
		head.flags  = in_data.flags;
		head.d      = in_data.span;
		head.lx.num = in_data.nx[MAG_W-1:0];
		head.lx.rem = RT_W'(in_data.nx[N_W-1:MAG_W]);
		head.lx.q   = '0;
		head.ly.num = in_data.ny[MAG_W-1:0];
		head.ly.rem = RT_W'(in_data.ny[N_W-1:MAG_W]);
		head.ly.q   = '0;
	end

	for (genvar i = 0; i < MAG_STEPS; i++) begin : g_step
		cstage_t cur, nxt;
		logic    cur_v;

		if (i == 0) begin : g_first
			assign cur   = head;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = pipe_s[i-1];
			assign cur_v = v_s[i-1];
		end

		always_comb begin
			nxt    = cur;
			nxt.lx = lane_step(cur.lx, cur.d);
			nxt.ly = lane_step(cur.ly, cur.d);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_s[i] <= nxt;
			end
		end
	end

	assign out_valid      = v_s[MAG_STEPS-1];
	assign out_data.flags = pipe_s[MAG_STEPS-1].flags;
	assign out_data.qx    = pipe_s[MAG_STEPS-1].lx.q;
	assign out_data.qy    = pipe_s[MAG_STEPS-1].ly.q;

endmodule

[rtl/pair_gravity_force_top.sv]
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  in_data   (pgf_pkg::in_t)
// result    out        out_valid / out_stall out_data (pgf_pkg::out_t)
// config    in         cfg_we               cfg_index, cfg_data
//
// One request per cycle while in_stall is low; each result passes through
// 4 setup stages, 60 steps of the G*m1*m2/r2 divider with the root in its
// first 33, 2 multiply stages, 60 steps of the dual division by distance,
// and one output register. Reset clears all valid bits and loads the register
// defaults. While a result waits under out_stall the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
module pair_gravity_force_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  pgf_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output pgf_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic [pgf_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pgf_pkg::C_W-1:0]     cfg_data
);
	import pgf_pkg::*;

	logic                  adv;
	logic [C_W-1:0]        gravity_q;
	logic                  gate_q;
	logic signed [C_W-1:0] level_q;

	logic   prep_v, mag_v, scale_v, comp_v;
	prep_t  prep_d;
	mag_t   mag_d;
	scale_t scale_d;
	comp_t  comp_d;

	logic          out_valid_q;
	out_t          out_q;
	out_t          res;
	logic [F_W:0]  cx, cy;

	// Clamp a quotient to the signed force range; msb flags clipping
	function automatic logic [F_W:0] clip(input logic neg, input logic [MAG_W-1:0] q);
		logic           over;
		logic [F_W-1:0] v;
		if (neg) begin
			over = (q[MAG_W-1:F_W] != '0) || (q[F_W-1] && (q[F_W-2:0] != '0));
		end else begin
			over = (q[MAG_W-1:F_W-1] != '0);
		end
		if (over) begin
			v = neg ? NEG_LIM : POS_LIM;
		end else if (neg) begin
			v = -q[F_W-1:0];
		end else begin
			v = q[F_W-1:0];
		end
		return {over, v};
	endfunction

	// Advance everything unless a finished result is held
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= G_RESET;
			gate_q    <= 1'b0;
			level_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAVITY: gravity_q <= cfg_data;
				REG_GATE:    gate_q    <= cfg_data[0];
				REG_LEVEL:   level_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	pgf_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.gravity   (gravity_q),
		.gate_en   (gate_q),
		.level     (level_q),
		.out_valid (prep_v),
		.out_data  (prep_d)
	);

	pgf_mag u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (prep_v),
		.in_data   (prep_d),
		.out_valid (mag_v),
		.out_data  (mag_d)
	);

	pgf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (mag_v),
		.in_data   (mag_d),
		.out_valid (scale_v),
		.out_data  (scale_d)
	);

	pgf_comp u_comp (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (scale_v),
		.in_data   (scale_d),
		.out_valid (comp_v),
		.out_data  (comp_d)
	);

	// Apply signs, saturate, and zero gated or short-range pairs
	always_comb begin
		cx          = clip(comp_d.flags.neg_x, comp_d.qx);
		cy          = clip(comp_d.flags.neg_y, comp_d.qy);
		res.applied = comp_d.flags.applied;
		if (comp_d.flags.zero) begin
			res.force_x   = '0;
			res.force_y   = '0;
			res.saturated = 1'b0;
		end else begin
			res.force_x   = cx[F_W-1:0];
			res.force_y   = cy[F_W-1:0];
			res.saturated = cx[F_W] | cy[F_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= comp_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[rtl/pgf_checker.sv]
`include "pair_gravity_force_top_defines.svh"

module pgf_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input pgf_pkg::out_t out_data
);
	import pgf_pkg::*;

	// Held result stays put
	`PGF_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "held result changed")

	// Free output never blocks requests
	`PGF_ASSERT_IMP(a_flow, out_valid && !out_stall, !in_stall, "stalled with free output")

	// Gated results carry no force
	`PGF_ASSERT_IMP(a_gate, out_valid && !out_data.applied, (out_data.force_x == '0) && (out_data.force_y == '0) && !out_data.saturated, "gated result has force")

	// Clipping lands on a range limit
	`PGF_ASSERT_IMP(a_clip, out_valid && out_data.saturated, out_data.applied && ((out_data.force_x == POS_LIM) || (out_data.force_x == NEG_LIM) || (out_data.force_y == POS_LIM) || (out_data.force_y == NEG_LIM)), "clip flag without limit")

endmodule

bind pair_gravity_force_top pgf_checker u_pgf_checker (.*);

[tb/sv/tb_pair_gravity_force_top.sv]
module tb_pair_gravity_force_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pgf_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 160;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [C_W-1:0] cfg_data;

	// local copy of the configuration registers
	logic [C_W-1:0] g_const;
	logic gate_on;
	logic signed [C_W-1:0] water_y;

	in_t pair_queue[$];
	out_t force_queue[$];
	bit failed;
	bit taken;
	int burst_left;
	int gap_left;
	int stall_pct;
	int stall_cnt;

	pair_gravity_force_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// scale one component and clip it to 48 bits
	function automatic logic [F_W-1:0] axis_force(logic neg, logic [127:0] mag,
			logic [127:0] a, logic [127:0] span, inout logic sat);
		logic [127:0] q;
		q = (mag * a) / span;
		q = {64'd0, q[63:0]};
		if (!neg) begin
			if (q > 128'(POS_LIM)) begin
				q = 128'(POS_LIM);
				sat = 1'b1;
			end
			return q[F_W-1:0];
		end
		if (q > 128'(NEG_LIM)) begin
			q = 128'(NEG_LIM);
			sat = 1'b1;
		end
		return F_W'(-q);
	endfunction

	// expected force on the first body
	function automatic out_t pair_force(in_t p);
		longint dx, dy;
		logic [127:0] ax, ay, r2, span, t, k, mag;
		out_t r;
		logic sat;
		dx = longint'(p.second_x) - longint'(p.first_x);
		dy = longint'(p.second_y) - longint'(p.first_y);
		ax = 128'(dx < 0 ? -dx : dx);
		ay = 128'(dy < 0 ? -dy : dy);
		r2 = ax * ax + ay * ay;
		sat = 1'b0;
		r = '0;
		r.applied = !(gate_on && p.first_y <= water_y);
		if (r.applied && r2 >= (128'd25 << 32)) begin
			span = '0;
			for (int b = 34; b >= 0; b--) begin
				t = span | (128'd1 << b);
				if (t * t <= r2)
					span = t;
			end
			k = (128'(g_const) * 128'(p.first_mass)) * 128'(p.second_mass);
			mag = k / r2;
			mag = {64'd0, mag[63:0]};
			r.force_x = axis_force(dx < 0, mag, ax, span, sat);
			r.force_y = axis_force(dy < 0, mag, ay, span, sat);
		end
		r.saturated = sat;
		return r;
	endfunction

	function automatic in_t random_pair();
		in_t p;
		int unsigned near;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		near = $urandom_range(0, 3);
		// in half the cases place the bodies within reach of each other
		if (near == 1) begin
			p.second_x = p.first_x + C_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
			p.second_y = p.first_y + C_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		end else if (near == 2) begin
			p.second_x = p.first_x + C_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			p.second_y = p.first_y + C_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			p.first_mass = $urandom_range(0, 1 << 22);
			p.second_mass = $urandom_range(0, 1 << 22);
		end
		return p;
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [C_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRAVITY: g_const = val;
			REG_GATE: gate_on = val[0];
			REG_LEVEL: water_y = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pair_queue.size() != 0 || force_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_random(int n);
		repeat (n) pair_queue.push_back(random_pair());
	endtask

	function automatic in_t mk(int x1, int y1, int unsigned m1, int x2, int y2,
			int unsigned m2);
		in_t p;
		p.first_x = x1;
		p.first_y = y1;
		p.first_mass = m1;
		p.second_x = x2;
		p.second_y = y2;
		p.second_mass = m2;
		return p;
	endfunction

	// request driver: bursts with random gaps, holds while stalled
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !taken) begin
				// hold
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pair_queue.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pair_queue[0];
				taken = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
			// result stall pattern, density changes over time
			if (stall_cnt == 0) begin
				stall_cnt = $urandom_range(50, 300);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			stall_cnt--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// accept requests and check results
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall && !taken) begin
				force_queue.push_back(pair_force(pair_queue.pop_front()));
				taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (force_queue.size() == 0) begin
					$error("unexpected result force_x=%h", out_data.force_x);
					failed = 1'b1;
				end else begin
					exp_r = force_queue.pop_front();
					if (out_data.force_x !== exp_r.force_x) begin
						$error("force_x expected %h got %h", exp_r.force_x, out_data.force_x);
						failed = 1'b1;
					end
					if (out_data.force_y !== exp_r.force_y) begin
						$error("force_y expected %h got %h", exp_r.force_y, out_data.force_y);
						failed = 1'b1;
					end
					if (out_data.applied !== exp_r.applied) begin
						$error("applied expected %b got %b", exp_r.applied, out_data.applied);
						failed = 1'b1;
					end
					if (out_data.saturated !== exp_r.saturated) begin
						$error("saturated expected %b got %b", exp_r.saturated,
							out_data.saturated);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		failed = 1'b0;
		taken = 1'b1;
		burst_left = 0;
		gap_left = 0;
		stall_cnt = 0;
		stall_pct = 0;
		g_const = G_RESET;
		gate_on = 1'b0;
		water_y = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, short distance, boundary at five, saturation
		pair_queue.push_back(mk(0, 0, 1 << 16, 0, 0, 1 << 16));
		pair_queue.push_back(mk(0, 0, 1 << 16, 4 << 16, 0, 1 << 16));
		pair_queue.push_back(mk(0, 0, 1 << 16, 5 << 16, 0, 1 << 16));
		pair_queue.push_back(mk(0, 0, 1 << 16, (5 << 16) - 1, 0, 1 << 16));
		pair_queue.push_back(mk(0, 0, 1 << 16, 3 << 16, 4 << 16, 1 << 16));
		pair_queue.push_back(mk(0, 0, 1 << 16, -(3 << 16), -(4 << 16), 1 << 16));
		pair_queue.push_back(mk(32'h8000_0000, 32'h8000_0000, '1,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, '1));
		pair_queue.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
			32'h8000_0000, 32'h8000_0000, '1));
		pair_queue.push_back(mk(0, 0, '1, 5 << 16, 0, '1));
		pair_queue.push_back(mk(0, 0, '1, 0, -(5 << 16), '1));
		pair_queue.push_back(mk(0, 0, 0, 10 << 16, 10 << 16, '1));
		pair_queue.push_back(mk(0, 0, '1, 6 << 16, 1, 0));
		pair_queue.push_back(mk(-5, 7, 1 << 20, 100 << 16, -(200 << 16), 1 << 24));
		add_random(110);
		drain();

		// saturating G, gate on at a random level, then an equal-y case
		write_reg(REG_GRAVITY, '1);
		write_reg(REG_GATE, 32'd3);
		write_reg(REG_LEVEL, $urandom);
		pair_queue.push_back(mk(0, water_y, '1, 5 << 16, water_y, '1));
		pair_queue.push_back(mk(0, water_y + 1, '1, 5 << 16, water_y, '1));
		pair_queue.push_back(mk(0, water_y - 1, '1, 5 << 16, water_y, '1));
		add_random(120);
		drain();

		// zero G, gate cleared by an even value, lowest level
		write_reg(REG_GRAVITY, '0);
		write_reg(REG_GATE, 32'hFFFF_FFFE);
		write_reg(REG_LEVEL, 32'h8000_0000);
		add_random(60);
		drain();

		// highest level gates everything off; unused index must do nothing
		write_reg(REG_GRAVITY, $urandom);
		write_reg(REG_GATE, 32'd1);
		write_reg(REG_LEVEL, 32'h7FFF_FFFF);
		write_reg(REG_UNUSED, 32'h0000_0000);
		pair_queue.push_back(mk(0, 32'h7FFF_FFFF, '1, 9 << 16, 0, '1));
		add_random(60);
		drain();

		// gate at lowest level: only first_y equal to it is gated
		write_reg(REG_GRAVITY, 32'h0001_0000);
		write_reg(REG_LEVEL, 32'h8000_0000);
		write_reg(REG_UNUSED, '1);
		pair_queue.push_back(mk(0, 32'h8000_0000, '1, 9 << 16, 0, '1));
		add_random(120);
		drain();

		write_reg(REG_GRAVITY, $urandom_range(0, 1 << 20));
		write_reg(REG_GATE, 32'd0);
		write_reg(REG_LEVEL, 32'd0);
		add_random(100);
		drain();

		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
